// ----- hdl/square_image_rotate_90_unit_assert.svh -----
// Assertion macros shared by the rotate-90 unit RTL.
// Depends on a clock named clock and a synchronous reset named reset in the using module.
`ifndef SQUARE_IMAGE_ROTATE_90_UNIT_ASSERT_SVH
`define SQUARE_IMAGE_ROTATE_90_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SIR90_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define SIR90_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// ----- hdl/sir90_pkg.sv -----
// Package for the rotate-90 unit: size constants, payload structs, FSM state and command types.
// No dependencies.
package sir90_pkg;

   localparam int MaxSide    = 64;
   localparam int StoreDepth = MaxSide * MaxSide;
   localparam int AddrWidth  = $clog2(StoreDepth);
   localparam int CoordWidth = $clog2(MaxSide);
   localparam int SideWidth  = $clog2(MaxSide + 1);
   localparam int SizeWidth  = 7;
   localparam int PixelWidth = 32;

   typedef enum logic [0:0] {
      FUNC_LOAD  = 1'b0,
      FUNC_FETCH = 1'b1
   } func_type;

   typedef struct packed {
      logic                  func;
      logic [PixelWidth-1:0] pixel_in;
   } req_type;

   typedef struct packed {
      logic [PixelWidth-1:0] pixel_out;
      logic                  last;
   } rsp_type;

   typedef enum logic [0:0] {
      ST_SETUP,
      ST_RUN
   } ctl_state_type;

   typedef struct packed {
      logic setup;       // recompute base addresses and clear positions
      logic size_write;  // capture a new image size
      logic load;        // write the next raster pixel
      logic fetch;       // read the next rotated pixel
   } dp_cmd_type;

endpackage

// ----- hdl/sir90_dp.sv -----
// Datapath of the rotate-90 unit: frame store, load and fetch address counters, result register.
// Depends on sir90_pkg.
module sir90_dp
   import sir90_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  dp_cmd_type           cmd,
   input  req_type              req_payload,
   input  logic [SizeWidth-1:0] csr_wdata,
   output rsp_type              rsp_payload
);

   logic [PixelWidth-1:0] frame_mem [StoreDepth];

   logic [SideWidth-1:0]  side_ff,      side_in;
   logic [AddrWidth-1:0]  base_ff,      base_in;
   logic [AddrWidth-1:0]  load_last_ff, load_last_in;
   logic [AddrWidth-1:0]  load_pos_ff,  load_pos_in;
   logic [AddrWidth-1:0]  raddr_ff,     raddr_in;
   logic [CoordWidth-1:0] row_ff,       row_in;
   logic [CoordWidth-1:0] col_ff,       col_in;
   logic [PixelWidth-1:0] pixel_ff;
   logic                  last_ff;

   logic [CoordWidth-1:0] side_m1;
   logic [AddrWidth-1:0]  base_prod;
   logic [SideWidth-1:0]  side_new;
   logic                  col_end;
   logic                  row_end;

   assign side_m1   = CoordWidth'(side_ff - SideWidth'(1));
   assign base_prod = AddrWidth'(side_m1) * AddrWidth'(side_ff);
   assign col_end   = (col_ff == side_m1);
   assign row_end   = (row_ff == side_m1);

   // A size of zero acts as one; sizes beyond the store saturate.
   always_comb begin
      if (csr_wdata == '0) begin
         side_new = SideWidth'(1);
      end else if (int'(csr_wdata) > MaxSide) begin
         side_new = SideWidth'(MaxSide);
      end else begin
         side_new = SideWidth'(csr_wdata);
      end
   end

   always_comb begin
      side_in      = side_ff;
      base_in      = base_ff;
      load_last_in = load_last_ff;
      load_pos_in  = load_pos_ff;
      raddr_in     = raddr_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      if (cmd.size_write) begin
         side_in = side_new;
      end
      if (cmd.setup) begin
         base_in      = base_prod;
         load_last_in = base_prod + AddrWidth'(side_m1);
         load_pos_in  = '0;
         raddr_in     = base_prod;
         row_in       = '0;
         col_in       = '0;
      end
      if (cmd.load) begin
         load_pos_in = (load_pos_ff == load_last_ff) ? '0 : load_pos_ff + AddrWidth'(1);
      end
      if (cmd.fetch) begin
         if (!col_end) begin
            col_in   = col_ff + CoordWidth'(1);
            raddr_in = raddr_ff - AddrWidth'(side_ff);
         end else begin
            col_in   = '0;
            row_in   = row_end ? '0 : row_ff + CoordWidth'(1);
            raddr_in = base_ff + AddrWidth'(row_in);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff      <= SideWidth'(MaxSide);
         base_ff      <= '0;
         load_last_ff <= '0;
         load_pos_ff  <= '0;
         raddr_ff     <= '0;
         row_ff       <= '0;
         col_ff       <= '0;
      end else begin
         side_ff      <= side_in;
         base_ff      <= base_in;
         load_last_ff <= load_last_in;
         load_pos_ff  <= load_pos_in;
         raddr_ff     <= raddr_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         frame_mem[load_pos_ff] <= req_payload.pixel_in;
      end
      if (cmd.fetch) begin
         pixel_ff <= frame_mem[raddr_ff];
         last_ff  <= col_end && row_end;
      end
   end

   assign rsp_payload.pixel_out = pixel_ff;
   assign rsp_payload.last      = last_ff;

endmodule

// ----- hdl/sir90_ctl.sv -----
// Controller of the rotate-90 unit: setup/run state machine, handshakes and datapath commands.
// Depends on sir90_pkg and square_image_rotate_90_unit_assert.svh.
`include "square_image_rotate_90_unit_assert.svh"

module sir90_ctl
   import sir90_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic       req_func,
   input  logic       csr_valid,
   output logic       csr_ready,
   output logic       busy,
   output logic       rsp_valid,
   output dp_cmd_type cmd
);

   ctl_state_type state_ff, state_in;
   logic          rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SETUP;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= cmd.fetch;
      end
   end

   // All command bits come from this one block; a transaction is taken whenever
   // start is high in a cycle where busy is low.
   always_comb begin
      state_in  = state_ff;
      busy      = 1'b1;
      csr_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         ST_SETUP: begin
            cmd.setup = 1'b1;
            state_in  = ST_RUN;
         end
         ST_RUN: begin
            busy           = 1'b0;
            csr_ready      = 1'b1;
            cmd.size_write = csr_valid;
            if (csr_valid) begin
               state_in = ST_SETUP;
            end
         end
         default: begin
            state_in = ST_SETUP;
         end
      endcase
      cmd.load  = start && !busy && (req_func == FUNC_LOAD);
      cmd.fetch = start && !busy && (req_func == FUNC_FETCH);
   end

   assign rsp_valid = rsp_valid_ff;

   `SIR90_ASSERT_NEXT(a_fetch_gives_rsp, cmd.fetch, rsp_valid)
   `SIR90_ASSERT_NEXT(a_size_write_setup, csr_valid && csr_ready, busy && cmd.setup)
   `SIR90_ASSERT_NEXT(a_setup_one_cycle, cmd.setup, !busy && !cmd.setup)
   `SIR90_ASSERT_SAME(a_rsp_has_fetch, rsp_valid, $past(cmd.fetch))

endmodule

// ----- hdl/square_image_rotate_90_unit.sv -----
// Top level of the rotate-90 unit: ties the controller to the frame-store datapath.
// Depends on sir90_pkg, sir90_ctl and sir90_dp.
//
// Usage. The unit turns a square image of 32-bit pixels by 90 degrees clockwise.
// Input transactions are accepted on a rising edge with start high and busy low.
// A load transaction (func = 0) writes pixel_in into the frame store at the next
// raster position; it produces no result. A fetch transaction (func = 1) reads
// the next pixel of the rotated image in raster order. Both positions wrap after
// n*n transactions. A fetched pixel is meaningful only once a full frame is loaded.
// Latency and throughput: one transaction per clock while busy is low. A fetch
// result appears on rsp_payload with rsp_valid high for exactly one cycle, the
// cycle after the fetch was accepted, set by the registered read of the frame store.
// The receiver cannot stall; it must take each result in that cycle.
// Configuration: the image side n is written on the csr channel (valid/ready).
// A write restarts both streams; the frame store keeps its contents. After the
// write, busy stays high for one cycle while the row base address (n-1)*n is
// computed by the single multiplier. Reset sets n to 64, clears the positions and
// likewise holds busy for one setup cycle. The store itself is not cleared.
module square_image_rotate_90_unit
   import sir90_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  req_type              req_payload,
   output logic                 rsp_valid,
   output rsp_type              rsp_payload,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [SizeWidth-1:0] csr_wdata
);

   // Commands from the controller to the datapath.
   dp_cmd_type cmd;

   // The controller owns the handshakes and the setup sequence.
   sir90_ctl u_ctl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_func  (req_payload.func),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   // The datapath holds the frame store and steps the read address by -n on each
   // fetch, jumping to the bottom row of the next column at each row end.
   sir90_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_payload (req_payload),
      .csr_wdata   (csr_wdata),
      .rsp_payload (rsp_payload)
   );

endmodule
